[src/wds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_pkg
// Shared constants and types for the disparity select block.
// ----------------------------------------------------------------------------
package wds_pkg;

  localparam int DISP_LIMIT_DEF = 128;
  localparam int COST_BITS_DEF  = 16;

  localparam int DISP_W     = 8;
  localparam int RATIO_W    = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;
  localparam int RATIO_FRAC = 16;

  // disparities this close to each other never reject
  localparam int NEAR_DISP = 2;

  localparam logic [RATIO_W-1:0] RATIO_RESET   = RATIO_W'(62259);
  localparam logic [DISP_W-1:0]  INVALID_RESET = DISP_W'(255);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_RATIO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CODE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [DISP_W-1:0] best_index;
    logic [DISP_W-1:0] runner_index;
    logic              runner_found;
  } pick_t;

endpackage

[src/wds_cost_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_cost_tracker
// Running minimum and second distinct minimum over the costs of one pixel.
// ----------------------------------------------------------------------------
module wds_cost_tracker #(
  parameter int DISP_LIMIT = wds_pkg::DISP_LIMIT_DEF,
  parameter int COST_BITS  = wds_pkg::COST_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 last_i,
  input  logic [COST_BITS-1:0] cost_i,
  output logic [COST_BITS-1:0] best_cost_o,
  output logic [COST_BITS-1:0] runner_cost_o,
  output wds_pkg::pick_t       pick_o
);
  import wds_pkg::*;

  localparam int CNT_W = $clog2(DISP_LIMIT + 1);

  logic [COST_BITS-1:0] best_cost_q, best_cost_d;
  logic [COST_BITS-1:0] runner_cost_q, runner_cost_d;
  pick_t                pick_q, pick_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 open_slot;

  assign open_slot = (cnt_q < CNT_W'(DISP_LIMIT));

  // state after taking this cost, before the end-of-pixel clear
  always_comb begin
    best_cost_d   = best_cost_q;
    runner_cost_d = runner_cost_q;
    pick_d        = pick_q;
    cnt_d         = cnt_q;
    if (open_slot) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == '0) begin
        best_cost_d       = cost_i;
        pick_d.best_index = DISP_W'(cnt_q);
      end else if (cost_i < best_cost_q) begin
        runner_cost_d       = best_cost_q;
        pick_d.runner_index = pick_q.best_index;
        pick_d.runner_found = 1'b1;
        best_cost_d         = cost_i;
        pick_d.best_index   = DISP_W'(cnt_q);
      end else if ((cost_i > best_cost_q) &&
                   (!pick_q.runner_found || (cost_i < runner_cost_q))) begin
        runner_cost_d       = cost_i;
        pick_d.runner_index = DISP_W'(cnt_q);
        pick_d.runner_found = 1'b1;
      end
    end
  end

  assign best_cost_o   = best_cost_d;
  assign runner_cost_o = runner_cost_d;
  assign pick_o        = pick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cost_q   <= '1;
      runner_cost_q <= '1;
      pick_q        <= '0;
      cnt_q         <= '0;
    end else if (take_i) begin
      if (last_i) begin
        best_cost_q   <= '1;
        runner_cost_q <= '1;
        pick_q        <= '0;
        cnt_q         <= '0;
      end else begin
        best_cost_q   <= best_cost_d;
        runner_cost_q <= runner_cost_d;
        pick_q        <= pick_d;
        cnt_q         <= cnt_d;
      end
    end
  end

endmodule

[src/wds_unique_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_unique_check
// Uniqueness ratio test and final disparity choice for one pixel.
// ----------------------------------------------------------------------------
module wds_unique_check #(
  parameter int COST_BITS = wds_pkg::COST_BITS_DEF
) (
  input  logic [wds_pkg::RATIO_W-1:0] ratio_i,
  input  logic [wds_pkg::DISP_W-1:0]  invalid_code_i,
  input  logic [COST_BITS-1:0]        best_cost_i,
  input  logic [COST_BITS-1:0]        runner_cost_i,
  input  wds_pkg::pick_t              pick_i,
  output logic [wds_pkg::DISP_W-1:0]  disparity_o,
  output logic                        rejected_o
);
  import wds_pkg::*;

  localparam int PROD_W = RATIO_W + COST_BITS;

  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic [DISP_W-1:0] diff;
  logic              reject;

  // best * 2^16 against ratio * runner, exact
  assign lhs = PROD_W'({best_cost_i, {RATIO_FRAC{1'b0}}});
  assign rhs = PROD_W'(ratio_i) * PROD_W'(runner_cost_i);

  assign diff = (pick_i.best_index > pick_i.runner_index)
              ? (pick_i.best_index - pick_i.runner_index)
              : (pick_i.runner_index - pick_i.best_index);

  assign reject = pick_i.runner_found && (lhs > rhs) && (diff > DISP_W'(NEAR_DISP));

  assign disparity_o = reject ? invalid_code_i : pick_i.best_index;
  assign rejected_o  = reject;

endmodule

[src/wta_disparity_uniqueness_select.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted cost word goes to the input register; the pixel's
//   result word is loaded from there into the result register (two register stages).
// Throughput: one cost word per cycle, set by the update of the running
//   minimum registers; the input stalls only when a last-of-pixel word
//   meets a result word still held by the output stall.
// Reset: rst_ni clears pixel state, empties both stages, restores registers.
// ----------------------------------------------------------------------------
// wta_disparity_uniqueness_select
// Winner-take-all disparity select with uniqueness ratio rejection.
// ----------------------------------------------------------------------------
module wta_disparity_uniqueness_select #(
  parameter int DISP_LIMIT = wds_pkg::DISP_LIMIT_DEF,
  parameter int COST_BITS  = wds_pkg::COST_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cost words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COST_BITS-1:0]           cost_value_i,
  input  logic                           last_of_pixel_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wds_pkg::DISP_W-1:0]     disparity_o,
  output logic                           rejected_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wds_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wds_pkg::*;

  // configuration registers
  logic [RATIO_W-1:0] ratio_q;
  logic [DISP_W-1:0]  invalid_code_q;

  // input register stage
  logic                 in_valid_q;
  logic [COST_BITS-1:0] cost_q;
  logic                 last_q;

  // result register stage
  logic              out_valid_q;
  logic [DISP_W-1:0] disparity_q;
  logic              rejected_q;

  logic                 in_accept;
  logic                 drain;      // stage-1 word is consumed this cycle
  logic                 out_free;   // result register can take a word
  logic [COST_BITS-1:0] best_cost;
  logic [COST_BITS-1:0] runner_cost;
  pick_t                pick;
  logic [DISP_W-1:0]    disparity;
  logic                 rejected;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q        <= RATIO_RESET;
      invalid_code_q <= INVALID_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_UNIQUE_RATIO: ratio_q        <= cfg_data_i[RATIO_W-1:0];
        CFG_INVALID_CODE: invalid_code_q <= cfg_data_i[DISP_W-1:0];
        default: ;
      endcase
    end
  end

  // Only last-of-pixel words need the result register; other words always
  // drain, so the pipe keeps moving while a result waits.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign drain      = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !drain;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (drain) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cost_q <= cost_value_i;
      last_q <= last_of_pixel_i;
    end
  end

  wds_cost_tracker #(
    .DISP_LIMIT (DISP_LIMIT),
    .COST_BITS  (COST_BITS)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (drain),
    .last_i        (last_q),
    .cost_i        (cost_q),
    .best_cost_o   (best_cost),
    .runner_cost_o (runner_cost),
    .pick_o        (pick)
  );

  wds_unique_check #(
    .COST_BITS (COST_BITS)
  ) u_check (
    .ratio_i        (ratio_q),
    .invalid_code_i (invalid_code_q),
    .best_cost_i    (best_cost),
    .runner_cost_i  (runner_cost),
    .pick_i         (pick),
    .disparity_o    (disparity),
    .rejected_o     (rejected)
  );

  // result register: loads on a draining last word, empties when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (drain && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain && last_q) begin
      disparity_q <= disparity;
      rejected_q  <= rejected;
    end
  end

  assign out_valid_o = out_valid_q;
  assign disparity_o = disparity_q;
  assign rejected_o  = rejected_q;

endmodule
